/* rtl/pidci_pkg.sv */
`timescale 1ns / 1ps
// pidci_pkg: shared types and constants for the clamped-integrator pid controller
// no dependencies; imported by every module under rtl

package pidci_pkg;

    // data format
    localparam int DATA_W    = 32;
    localparam int FRAC_BITS = 24;
    localparam int CFG_IDX_W = 3;

    // register reset values
    localparam logic signed [DATA_W-1:0] UPPER_RESET = 32'sd16777216;
    localparam logic signed [DATA_W-1:0] LOWER_RESET = -32'sd16777216;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROP_GAIN   = 3'd0,
        REG_INTEG_GAIN  = 3'd1,
        REG_DERIV_GAIN  = 3'd2,
        REG_UPPER_LIMIT = 3'd3,
        REG_LOWER_LIMIT = 3'd4
    } t_cfg_idx;

    // limit status codes, also the saturation mode of the last output
    typedef enum logic [1:0] {
        LIM_NONE  = 2'd0,
        LIM_UPPER = 2'd1,
        LIM_LOWER = 2'd2
    } t_limit;

    // configuration register set
    typedef struct packed {
        logic signed [DATA_W-1:0] prop_gain;
        logic signed [DATA_W-1:0] integ_gain;
        logic signed [DATA_W-1:0] deriv_gain;
        logic signed [DATA_W-1:0] upper_limit;
        logic signed [DATA_W-1:0] lower_limit;
    } t_cfg;

    // item held in the input register
    typedef struct packed {
        logic signed [DATA_W-1:0] err;
        logic signed [DATA_W-1:0] feedforward;
    } t_stage;

endpackage

/* rtl/pidci_cfg_regs.sv */
`timescale 1ns / 1ps
// pidci_cfg_regs: gain and limit registers behind the configuration write channel
// depends on pidci_pkg

module pidci_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [pidci_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pidci_pkg::DATA_W-1:0]     i_cfg_data,
    output pidci_pkg::t_cfg                  o_cfg
);
    import pidci_pkg::*;

    t_cfg r_cfg;

    // writes are always taken
    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // register file, unknown indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prop_gain   <= '0;
            r_cfg.integ_gain  <= '0;
            r_cfg.deriv_gain  <= '0;
            r_cfg.upper_limit <= UPPER_RESET;
            r_cfg.lower_limit <= LOWER_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_PROP_GAIN:   r_cfg.prop_gain   <= signed'(i_cfg_data);
                REG_INTEG_GAIN:  r_cfg.integ_gain  <= signed'(i_cfg_data);
                REG_DERIV_GAIN:  r_cfg.deriv_gain  <= signed'(i_cfg_data);
                REG_UPPER_LIMIT: r_cfg.upper_limit <= signed'(i_cfg_data);
                REG_LOWER_LIMIT: r_cfg.lower_limit <= signed'(i_cfg_data);
                default: ;
            endcase
        end
    end

endmodule

/* rtl/pidci_err_stage.sv */
`timescale 1ns / 1ps
// pidci_err_stage: input register, forms the saturated error on the way in
// depends on pidci_pkg

module pidci_err_stage (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic signed [pidci_pkg::DATA_W-1:0]  i_setpoint,
    input  logic signed [pidci_pkg::DATA_W-1:0]  i_measured,
    input  logic signed [pidci_pkg::DATA_W-1:0]  i_feedforward,
    output logic                                 o_stage_vld,
    input  logic                                 i_stage_ready,
    output pidci_pkg::t_stage                    o_stage
);
    import pidci_pkg::*;

    logic                     r_vld;
    t_stage                   r_stage;
    logic signed [DATA_W:0]   diff;
    logic signed [DATA_W-1:0] err_sat;
    logic                     take;

    // setpoint minus measured, saturated to the data range
    always_comb begin
        diff = {i_setpoint[DATA_W-1], i_setpoint} - {i_measured[DATA_W-1], i_measured};
        if (diff[DATA_W] != diff[DATA_W-1]) begin
            err_sat = diff[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end else begin
            err_sat = diff[DATA_W-1:0];
        end
    end

    // register is free when empty or draining this cycle
    assign o_stall     = r_vld && !i_stage_ready;
    assign take        = i_valid && !o_stall;
    assign o_stage_vld = r_vld;
    assign o_stage     = r_stage;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (take) begin
            r_vld <= 1'b1;
        end else if (i_stage_ready) begin
            r_vld <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_stage.err         <= err_sat;
            r_stage.feedforward <= i_feedforward;
        end
    end

endmodule

/* rtl/pidci_core.sv */
`timescale 1ns / 1ps
// pidci_core: pid terms, clamped integrator, loop state and result register
// depends on pidci_pkg

module pidci_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  pidci_pkg::t_cfg                      i_cfg,
    input  logic                                 i_stage_vld,
    output logic                                 o_stage_ready,
    input  pidci_pkg::t_stage                    i_stage,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [pidci_pkg::DATA_W-1:0]  o_drive,
    output logic [1:0]                           o_limit_status,
    output logic signed [pidci_pkg::DATA_W-1:0]  o_error_value
);
    import pidci_pkg::*;

    localparam int PROD_W = 2 * DATA_W;
    localparam int DPROD_W = 2 * DATA_W + 1;
    localparam int ACC_W = PROD_W + 2;
    localparam int SUM_W = PROD_W + 4;

    // loop state
    logic signed [DATA_W-1:0] r_integ;
    logic signed [DATA_W-1:0] r_prev_err;
    t_limit                   r_sat_mode;

    // result register
    logic                     r_out_vld;
    logic signed [DATA_W-1:0] r_drive;
    t_limit                   r_status;
    logic signed [DATA_W-1:0] r_err;

    logic                      advance;
    logic signed [DATA_W-1:0]  err;
    logic signed [PROD_W-1:0]  p_prod;
    logic signed [PROD_W-1:0]  p_term;
    logic signed [PROD_W-1:0]  i_prod;
    logic signed [PROD_W-1:0]  i_step;
    logic signed [ACC_W-1:0]   acc;
    logic signed [ACC_W-1:0]   acc_hi;
    logic signed [ACC_W-1:0]   up_acc;
    logic signed [ACC_W-1:0]   lo_acc;
    logic                      integ_en;
    logic signed [DATA_W-1:0]  n_integ;
    logic signed [DATA_W:0]    d_diff;
    logic signed [DPROD_W-1:0] d_prod;
    logic signed [DPROD_W-1:0] d_term;
    logic signed [SUM_W-1:0]   sum;
    logic signed [SUM_W-1:0]   up_sum;
    logic signed [SUM_W-1:0]   lo_sum;
    logic signed [DATA_W-1:0]  n_drive;
    t_limit                    n_status;

    // handshake: the result register frees when empty or taken
    assign o_stage_ready = !r_out_vld || !i_stall;
    assign advance       = i_stage_vld && o_stage_ready;
    assign err           = i_stage.err;

    // proportional term, floor shift
    assign p_prod = i_cfg.prop_gain * err;
    assign p_term = p_prod >>> FRAC_BITS;

    // integrator step and clamp, upper bound first
    assign i_prod = i_cfg.integ_gain * err;
    assign i_step = i_prod >>> FRAC_BITS;
    assign up_acc = {{(ACC_W-DATA_W){i_cfg.upper_limit[DATA_W-1]}}, i_cfg.upper_limit};
    assign lo_acc = {{(ACC_W-DATA_W){i_cfg.lower_limit[DATA_W-1]}}, i_cfg.lower_limit};

    always_comb begin
        acc    = {{(ACC_W-DATA_W){r_integ[DATA_W-1]}}, r_integ}
               + {{(ACC_W-PROD_W){i_step[PROD_W-1]}}, i_step};
        acc_hi = (acc > up_acc) ? up_acc : acc;
        case (r_sat_mode)
            LIM_NONE:  integ_en = 1'b1;
            LIM_UPPER: integ_en = err[DATA_W-1];
            LIM_LOWER: integ_en = !err[DATA_W-1] && (err != '0);
            default:   integ_en = 1'b0;
        endcase
        if (!integ_en) begin
            n_integ = r_integ;
        end else if (acc_hi < lo_acc) begin
            n_integ = i_cfg.lower_limit;
        end else begin
            n_integ = acc_hi[DATA_W-1:0];
        end
    end

    // derivative term on the error change
    assign d_diff = {err[DATA_W-1], err} - {r_prev_err[DATA_W-1], r_prev_err};
    assign d_prod = d_diff * i_cfg.deriv_gain;
    assign d_term = d_prod >>> FRAC_BITS;

    // wide sum and output clamp, upper bound tested first
    assign up_sum = {{(SUM_W-DATA_W){i_cfg.upper_limit[DATA_W-1]}}, i_cfg.upper_limit};
    assign lo_sum = {{(SUM_W-DATA_W){i_cfg.lower_limit[DATA_W-1]}}, i_cfg.lower_limit};

    always_comb begin
        sum = {{(SUM_W-PROD_W){p_term[PROD_W-1]}}, p_term}
            + {{(SUM_W-DATA_W){n_integ[DATA_W-1]}}, n_integ}
            + {{(SUM_W-DPROD_W){d_term[DPROD_W-1]}}, d_term}
            + {{(SUM_W-DATA_W){i_stage.feedforward[DATA_W-1]}}, i_stage.feedforward};
        if (sum > up_sum) begin
            n_drive  = i_cfg.upper_limit;
            n_status = LIM_UPPER;
        end else if (sum < lo_sum) begin
            n_drive  = i_cfg.lower_limit;
            n_status = LIM_LOWER;
        end else begin
            n_drive  = sum[DATA_W-1:0];
            n_status = LIM_NONE;
        end
    end

    // loop state and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ    <= '0;
            r_prev_err <= '0;
            r_sat_mode <= LIM_NONE;
            r_out_vld  <= 1'b0;
        end else begin
            if (advance) begin
                r_integ    <= n_integ;
                r_prev_err <= err;
                r_sat_mode <= n_status;
                r_out_vld  <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld  <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_drive  <= n_drive;
            r_status <= n_status;
            r_err    <= err;
        end
    end

    assign o_valid        = r_out_vld;
    assign o_drive        = r_drive;
    assign o_limit_status = r_status;
    assign o_error_value  = r_err;

endmodule

/* rtl/pid_controller_clamped_integrator.sv */
`timescale 1ns / 1ps
// pid_controller_clamped_integrator: top level of the pid controller
// depends on pidci_pkg, pidci_cfg_regs, pidci_err_stage, pidci_core
//
// channel   direction  handshake                 payload
// input     in         i_valid / o_stall         i_setpoint, i_measured, i_feedforward
// result    out        o_valid / i_stall         o_drive, o_limit_status, o_error_value
// config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// one item per cycle while the result channel is not stalled, set by the integrator
// and saturation-mode feedback through the core closing with no register between;
// a sample passes the input register, then the result register; a stall holds it.
// synchronous active-low reset clears gains, integrator and valids and restores
// the default limits.
// a stalled result holds; the input register keeps taking items until it is full.

module pid_controller_clamped_integrator (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic signed [pidci_pkg::DATA_W-1:0]  i_setpoint,
    input  logic signed [pidci_pkg::DATA_W-1:0]  i_measured,
    input  logic signed [pidci_pkg::DATA_W-1:0]  i_feedforward,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [pidci_pkg::DATA_W-1:0]  o_drive,
    output logic [1:0]                           o_limit_status,
    output logic signed [pidci_pkg::DATA_W-1:0]  o_error_value,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [pidci_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [pidci_pkg::DATA_W-1:0]         i_cfg_data
);
    import pidci_pkg::*;

    t_cfg   cfg;
    t_stage stage;
    logic   stage_vld;
    logic   stage_ready;

    // configuration registers
    pidci_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // input register with error forming
    pidci_err_stage u_err (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_setpoint    (i_setpoint),
        .i_measured    (i_measured),
        .i_feedforward (i_feedforward),
        .o_stage_vld   (stage_vld),
        .i_stage_ready (stage_ready),
        .o_stage       (stage)
    );

    // terms, state and result register
    pidci_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_stage_vld    (stage_vld),
        .o_stage_ready  (stage_ready),
        .i_stage        (stage),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_drive        (o_drive),
        .o_limit_status (o_limit_status),
        .o_error_value  (o_error_value)
    );

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// tb: self-checking bench for the clamped-integrator pid controller
// depends on pidci_pkg and pid_controller_clamped_integrator

module tb;

    import pidci_pkg::*;

    localparam int          CLK_HALF      = 5;
    localparam int          RESET_CYCLES  = 8;
    localparam int          SETTLE_CYCLES = 6;
    localparam int          HOLD_CYCLES   = 150;
    localparam int          IDLE_LIMIT    = 5000;
    localparam int          MAX_REPORTS   = 10;
    localparam int          RAND_PHASES   = 12;
    localparam int          PHASE_ITEMS   = 70;
    localparam int          FIX_ONE       = 1 << FRAC_BITS;
    localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;
    localparam longint      WIDE_MAX      = 64'sd2147483647;
    localparam longint      WIDE_MIN      = -64'sd2147483648;

    // one control sample and one controller output
    typedef struct {
        logic signed [DATA_W-1:0] setpoint;
        logic signed [DATA_W-1:0] measured;
        logic signed [DATA_W-1:0] feedforward;
    } t_sample;

    typedef struct {
        logic signed [DATA_W-1:0] drive;
        t_limit                   status;
        logic signed [DATA_W-1:0] err;
    } t_ctrl_out;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_valid = 1'b0;
    logic                       o_stall;
    logic signed [DATA_W-1:0]   i_setpoint = '0;
    logic signed [DATA_W-1:0]   i_measured = '0;
    logic signed [DATA_W-1:0]   i_feedforward = '0;
    logic                       o_valid;
    logic                       i_stall = 1'b0;
    logic signed [DATA_W-1:0]   o_drive;
    logic [1:0]                 o_limit_status;
    logic signed [DATA_W-1:0]   o_error_value;
    logic                       i_cfg_valid = 1'b0;
    logic                       o_cfg_ready;
    logic [CFG_IDX_W-1:0]       i_cfg_index = '0;
    logic [DATA_W-1:0]          i_cfg_data = '0;

    pid_controller_clamped_integrator dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_setpoint     (i_setpoint),
        .i_measured     (i_measured),
        .i_feedforward  (i_feedforward),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_drive        (o_drive),
        .o_limit_status (o_limit_status),
        .o_error_value  (o_error_value),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // shared bench state
    t_sample     sample_q[$];
    t_ctrl_out   ctrl_out_q[$];
    bit          quiet_phase = 1'b0;
    int unsigned holds_asked = 0;
    int unsigned holds_served = 0;
    int unsigned gap_left = 0;
    int unsigned stall_left = 0;
    bit          in_xfer = 1'b0;
    int unsigned fail_count = 0;
    int unsigned report_count = 0;
    int unsigned idle_cycles = 0;
    int unsigned n_samples = 0;
    int unsigned n_outputs = 0;
    int unsigned n_upper = 0;
    int unsigned n_lower = 0;
    int unsigned n_writes = 0;

    // controller model state
    t_cfg                     gains;
    logic signed [DATA_W-1:0] integ_acc = '0;
    logic signed [DATA_W-1:0] last_err = '0;
    t_limit                   sat_mode = LIM_NONE;

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // one controller step: error, three terms, gated integrator, clamped sum
    function automatic t_ctrl_out pid_step(input t_sample s);
        longint    diff, err, p_term, d_term, acc, total, hi, lo;
        t_ctrl_out r;
        hi   = longint'($signed(gains.upper_limit));
        lo   = longint'($signed(gains.lower_limit));
        diff = longint'(s.setpoint) - longint'(s.measured);
        err  = (diff > WIDE_MAX) ? WIDE_MAX : ((diff < WIDE_MIN) ? WIDE_MIN : diff);
        p_term = (longint'($signed(gains.prop_gain)) * err) >>> FRAC_BITS;
        // integrate unless the output sat on a limit and the error pushes further
        if (sat_mode == LIM_NONE || (sat_mode == LIM_UPPER && err < 0) ||
            (sat_mode == LIM_LOWER && err > 0)) begin
            acc = longint'(integ_acc) +
                  ((longint'($signed(gains.integ_gain)) * err) >>> FRAC_BITS);
            if (acc > hi) acc = hi;
            if (acc < lo) acc = lo;
            integ_acc = acc[DATA_W-1:0];
        end
        d_term = ((err - longint'(last_err)) * longint'($signed(gains.deriv_gain)))
                 >>> FRAC_BITS;
        last_err = err[DATA_W-1:0];
        total = p_term + longint'(integ_acc) + d_term + longint'(s.feedforward);
        // upper limit is tested first, which matters for inverted limits
        if (total > hi) begin
            r.drive  = gains.upper_limit;
            r.status = LIM_UPPER;
        end else if (total < lo) begin
            r.drive  = gains.lower_limit;
            r.status = LIM_LOWER;
        end else begin
            r.drive  = total[DATA_W-1:0];
            r.status = LIM_NONE;
        end
        sat_mode = r.status;
        r.err = err[DATA_W-1:0];
        return r;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet_phase || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // signed value scaled down by a random power of two
    function automatic logic signed [DATA_W-1:0] rand_scaled(input int unsigned min_shift);
        return $signed($urandom) >>> $urandom_range(min_shift, DATA_W - 1);
    endfunction

    // sample driver: holds a sample until its transfer, then an optional gap
    always @(negedge i_clk) begin : drv_proc
        t_sample nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || in_xfer) begin
            if (gap_left > 0) begin
                i_valid  <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (sample_q.size() > 0) begin
                nxt = sample_q.pop_front();
                i_setpoint    <= nxt.setpoint;
                i_measured    <= nxt.measured;
                i_feedforward <= nxt.feedforward;
                i_valid       <= 1'b1;
                gap_left      <= pick_gap();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // result receiver: random stalls plus requested long hold-offs
    always @(negedge i_clk) begin : recv_proc
        int unsigned pick;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (holds_served != holds_asked) begin
            holds_served <= holds_served + 1;
            stall_left   <= HOLD_CYCLES;
            i_stall      <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_stall    <= 1'b1;
        end else begin
            pick = quiet_phase ? 0 : $urandom_range(0, 99);
            if (pick < 75) begin
                i_stall <= 1'b0;
            end else if (pick < 96) begin
                i_stall    <= 1'b1;
                stall_left <= $urandom_range(0, 2);
            end else begin
                i_stall    <= 1'b1;
                stall_left <= $urandom_range(10, 40);
            end
        end
    end

    // monitor: check outputs, predict on sample transfers, watchdog
    always @(posedge i_clk) begin : mon_proc
        t_ctrl_out want;
        bit        busy;
        busy = 1'b0;
        in_xfer <= i_valid && !o_stall;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                busy = 1'b1;
                n_outputs++;
                if (o_limit_status == LIM_UPPER) n_upper++;
                if (o_limit_status == LIM_LOWER) n_lower++;
                if (ctrl_out_q.size() == 0) begin
                    fail_count++;
                    if (report_count < MAX_REPORTS) begin
                        report_count++;
                        $display("[%0t] output with none expected: drive=%0d st=%0d err=%0d",
                                 $time, o_drive, o_limit_status, o_error_value);
                    end
                end else begin
                    want = ctrl_out_q.pop_front();
                    if (o_drive !== want.drive || o_limit_status !== want.status ||
                        o_error_value !== want.err) begin
                        fail_count++;
                        if (report_count < MAX_REPORTS) begin
                            report_count++;
                            $display({"[%0t] mismatch: drive exp %0d got %0d, ",
                                      "st exp %0d got %0d, err exp %0d got %0d"},
                                     $time, want.drive, o_drive, want.status,
                                     o_limit_status, want.err, o_error_value);
                        end
                    end
                end
            end
            if (i_valid && !o_stall) begin
                busy = 1'b1;
                n_samples++;
                ctrl_out_q.push_back(pid_step('{i_setpoint, i_measured, i_feedforward}));
            end
            if (i_cfg_valid && o_cfg_ready) busy = 1'b1;
            idle_cycles = busy ? 0 : idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("[%0t] no transfer for %0d cycles", $time, IDLE_LIMIT);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // one register write transfer, mirrored into the model
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (t_cfg_idx'(idx))
            REG_PROP_GAIN:   gains.prop_gain   = val;
            REG_INTEG_GAIN:  gains.integ_gain  = val;
            REG_DERIV_GAIN:  gains.deriv_gain  = val;
            REG_UPPER_LIMIT: gains.upper_limit = val;
            REG_LOWER_LIMIT: gains.lower_limit = val;
            default: ;
        endcase
        n_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic program_all(input logic [DATA_W-1:0] kp, input logic [DATA_W-1:0] ki,
                               input logic [DATA_W-1:0] kd, input logic [DATA_W-1:0] hi,
                               input logic [DATA_W-1:0] lo);
        write_reg(REG_PROP_GAIN, kp);
        write_reg(REG_INTEG_GAIN, ki);
        write_reg(REG_DERIV_GAIN, kd);
        write_reg(REG_UPPER_LIMIT, hi);
        write_reg(REG_LOWER_LIMIT, lo);
    endtask

    task automatic add_sample(input logic signed [DATA_W-1:0] sp,
                              input logic signed [DATA_W-1:0] ms,
                              input logic signed [DATA_W-1:0] ff);
        sample_q.push_back('{sp, ms, ff});
    endtask

    // wait for every sample to be sent and every output to come back
    task automatic wait_drained();
        while (sample_q.size() != 0 || i_valid || ctrl_out_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // stimulus sequence
    initial begin
        logic signed [DATA_W-1:0] base, e, kp, ki, kd, hi, lo;
        int unsigned              run_left, style;
        bit                       neg;

        gains.prop_gain   = '0;
        gains.integ_gain  = '0;
        gains.deriv_gain  = '0;
        gains.upper_limit = UPPER_RESET;
        gains.lower_limit = LOWER_RESET;
        run_left = 0;
        neg      = 1'b0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: output is feedforward clamped, error saturates
        add_sample('0, '0, '0);
        add_sample(S32_MAX, S32_MIN, '0);
        add_sample(S32_MIN, S32_MAX, '0);
        add_sample('0, '0, S32_MAX);
        add_sample('0, '0, S32_MIN);
        add_sample(-1, -1, -1);
        wait_drained();

        // writes to unmapped indexes must leave every register alone
        for (int k = int'(REG_LOWER_LIMIT) + 1; k < (1 << CFG_IDX_W); k++)
            write_reg(CFG_IDX_W'(k), '0);
        add_sample('0, '0, FIX_ONE / 2);
        wait_drained();

        // wind up against the upper limit, hold, release, then the lower limit
        program_all(FIX_ONE, FIX_ONE / 4, FIX_ONE / 2, 4 * FIX_ONE, -4 * FIX_ONE);
        repeat (4) add_sample(2 * FIX_ONE, '0, '0);
        repeat (2) add_sample(FIX_ONE, '0, '0);
        repeat (2) add_sample('0, FIX_ONE, '0);
        repeat (4) add_sample('0, 3 * FIX_ONE, '0);
        repeat (2) add_sample(FIX_ONE / 2, '0, '0);
        wait_drained();

        // inverted limits
        program_all(FIX_ONE, FIX_ONE / 4, FIX_ONE / 2, -FIX_ONE, FIX_ONE);
        add_sample('0, '0, '0);
        add_sample(2 * FIX_ONE, '0, '0);
        add_sample(-2 * FIX_ONE, '0, '0);
        wait_drained();

        // extreme gains and full-range limits
        program_all(S32_MIN, S32_MAX, S32_MIN, S32_MAX, S32_MIN);
        add_sample(S32_MAX, S32_MIN, S32_MAX);
        add_sample(S32_MIN, S32_MAX, S32_MIN);
        add_sample(S32_MAX, S32_MIN, S32_MIN);
        wait_drained();

        // random phases, each with its own register settings
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            style = (ph == 0) ? 0 : ((ph == 1) ? 1 : $urandom_range(0, 9));
            kp = rand_scaled(4);
            ki = rand_scaled(8);
            kd = rand_scaled(4);
            hi = $urandom >> $urandom_range(1, DATA_W - 1);
            lo = -($urandom >> $urandom_range(1, DATA_W - 1));
            if (style == 0) begin
                kp = $urandom_range(0, 1) ? S32_MAX : S32_MIN;
                ki = $urandom_range(0, 1) ? S32_MAX : S32_MIN;
                kd = $urandom_range(0, 1) ? S32_MAX : S32_MIN;
                hi = S32_MAX;
                lo = S32_MIN;
            end else if (style == 1) begin
                lo = $urandom_range(0, 1) ? hi : hi + ($urandom >> $urandom_range(1, 31));
            end else if (style == 2) begin
                kp = $urandom;
                ki = $urandom;
                kd = $urandom;
                hi = $urandom;
                lo = $urandom;
            end
            program_all(kp, ki, kd, hi, lo);
            if ($urandom_range(0, 3) == 0)
                write_reg(CFG_IDX_W'($urandom_range(int'(REG_LOWER_LIMIT) + 1,
                                                    (1 << CFG_IDX_W) - 1)), $urandom);

            quiet_phase = (ph == 2 || ph == 5 || ph == 9);
            // receiver backs up while the sender keeps offering
            if (ph == 5) holds_asked++;

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 4) == 0) begin
                    add_sample($urandom, $urandom, $urandom);
                end else begin
                    // runs of same-sign error push the integrator into a limit
                    if (run_left == 0) begin
                        run_left = $urandom_range(1, 20);
                        neg      = $urandom_range(0, 1);
                    end
                    run_left--;
                    base = rand_scaled(1);
                    e    = $urandom >> $urandom_range(6, DATA_W - 1);
                    if (neg) e = -e;
                    add_sample(base, base - e, rand_scaled(8));
                end
            end
            wait_drained();
            quiet_phase = 1'b0;
        end

        wait_drained();
        $display("covered %0d samples and %0d outputs (%0d at upper, %0d at lower limit)",
                 n_samples, n_outputs, n_upper, n_lower);
        $display("%0d register writes over %0d random phases, %0d mismatches",
                 n_writes, RAND_PHASES, fail_count);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
